/* rtl/deq_pkg.sv */
// shared types, codes and defaults for the double-ended queue
package deq_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  add_front;
    logic  take_front;
    logic  add_back;
    logic  take_back;
    word_t value;
  } cell_ctrl_t;

endpackage

/* rtl/deq_if.sv */
// request and response channel interfaces
interface deq_req_if;
  logic                            valid;
  logic                            ready;
  logic [deq_pkg::OP_W-1:0]        op;
  logic signed [deq_pkg::WORD_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink (input valid, input op, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [deq_pkg::WORD_W-1:0] read_value;
  logic [deq_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output read_value, output status, input ready);
  modport sink (input valid, input read_value, input status, output ready);
endinterface

/* rtl/double_ended_queue.sv */
// double-ended queue top level: row of shifting cells and response register
// Takes one request per clock while the response register is free or being emptied,
// and returns its result in the cycle after acceptance; the row of cells
// shifts by one place on a front push or pop, while a back push writes only
// the first free cell after the tail and a back pop clears only the tail cell.
// The front word always sits in the first cell and the back word is picked
// from the one cell flagged as tail. A new request is taken while the previous
// result is being handed over. No clearing pass is needed after reset.
module double_ended_queue #(
  parameter int CAPACITY = deq_pkg::CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  deq_req_if.sink       req,
  deq_rsp_if.source     rsp
);

  deq_pkg::cell_ctrl_t ctrl;
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] prev_valid;
  logic [CAPACITY-1:0] next_valid;
  deq_pkg::word_t      cell_data [CAPACITY];
  deq_pkg::word_t      prev_data [CAPACITY];
  deq_pkg::word_t      next_data [CAPACITY];
  deq_pkg::word_t      back_data [CAPACITY];
  deq_pkg::word_t      back_word;
  deq_pkg::word_t      value_next;
  logic [deq_pkg::STATUS_W-1:0] status_next;
  logic fire;
  logic empty;
  logic full;

  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign empty     = !cell_valid[0];
  assign full      = cell_valid[CAPACITY-1];

  always_comb begin
    ctrl            = '0;
    ctrl.value      = req.push_value;
    ctrl.add_back   = fire && !full && (req.op == deq_pkg::OP_PUSH_BACK);
    ctrl.add_front  = fire && !full && (req.op == deq_pkg::OP_PUSH_FRONT);
    ctrl.take_back  = fire && !empty && (req.op == deq_pkg::OP_POP_BACK);
    ctrl.take_front = fire && !empty && (req.op == deq_pkg::OP_POP_FRONT);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
      assign prev_data[i]  = req.push_value;
    end else begin : g_body
      assign prev_valid[i] = cell_valid[i-1];
      assign prev_data[i]  = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_valid[i] = 1'b0;
      assign next_data[i]  = '0;
    end else begin : g_inner
      assign next_valid[i] = cell_valid[i+1];
      assign next_data[i]  = cell_data[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_valid[i]),
      .prev_data  (prev_data[i]),
      .next_valid (next_valid[i]),
      .next_data  (next_data[i]),
      .valid      (cell_valid[i]),
      .data       (cell_data[i]),
      .back_data  (back_data[i])
    );
  end

  // tail word, at most one cell flags itself as tail
  always_comb begin
    back_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_word = back_word | back_data[i];
    end
  end

  always_comb begin
    value_next  = '0;
    status_next = deq_pkg::ST_OK;
    case (req.op)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          value_next = back_word;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          value_next = cell_data[0];
        end
      end
      default: begin
        status_next = deq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.read_value <= value_next;
      rsp.status     <= status_next;
    end
  end

endmodule

/* rtl/deq_cell.sv */
// one storage cell of the shifting row, holds one word and its valid bit
module deq_cell (
  input  logic                clk,
  input  logic                rst,
  input  deq_pkg::cell_ctrl_t ctrl,
  input  logic                prev_valid,
  input  deq_pkg::word_t      prev_data,
  input  logic                next_valid,
  input  deq_pkg::word_t      next_data,
  output logic                valid,
  output deq_pkg::word_t      data,
  output deq_pkg::word_t      back_data
);

  logic first_free;
  logic is_back;

  assign first_free = !valid && prev_valid;
  assign is_back    = valid && !next_valid;
  assign back_data  = is_back ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.add_front) begin
      valid <= prev_valid;
    end else if (ctrl.take_front) begin
      valid <= next_valid;
    end else if (ctrl.add_back && first_free) begin
      valid <= 1'b1;
    end else if (ctrl.take_back && is_back) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.add_front) begin
      data <= prev_data;
    end else if (ctrl.take_front) begin
      data <= next_data;
    end else if (ctrl.add_back && first_free) begin
      data <= ctrl.value;
    end
  end

endmodule

/* rtl/deq_check.sv */
// port-level checks for the double-ended queue, bound to the top level
module deq_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic [deq_pkg::OP_W-1:0]           req_op,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [deq_pkg::WORD_W-1:0]  rsp_read_value,
  input logic [deq_pkg::STATUS_W-1:0]       rsp_status
);

  logic fire;
  logic is_push;
  logic is_read;

  assign fire    = req_valid && req_ready;
  assign is_push = (req_op == deq_pkg::OP_PUSH_BACK) || (req_op == deq_pkg::OP_PUSH_FRONT);
  assign is_read = (req_op == deq_pkg::OP_POP_BACK) || (req_op == deq_pkg::OP_POP_FRONT) ||
                   (req_op == deq_pkg::OP_PEEK_BACK) || (req_op == deq_pkg::OP_PEEK_FRONT);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("accepted request gave no result");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_status))
    else $error("stalled result changed");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    fire && is_push |=> rsp_status != deq_pkg::ST_EMPTY && rsp_read_value == '0)
    else $error("push gave empty status or a word");

  a_read_status: assert property (@(posedge clk) disable iff (rst)
    fire && is_read |=> rsp_status != deq_pkg::ST_FULL)
    else $error("pop or peek gave full status");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != deq_pkg::ST_OK |-> rsp_read_value == '0)
    else $error("error result carries a word");

endmodule

bind double_ended_queue deq_check u_deq_check (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_op         (req.op),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value),
  .rsp_status     (rsp.status)
);

/* sim/deq_checker.sv */
// watches the request and response channels, predicts each response and compares
module deq_checker (
  input  logic clk,
  input  logic rst,
  deq_req_if   req,
  deq_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  typedef struct packed {
    word_t                read_value;
    logic [STATUS_W-1:0]  status;
  } deq_result_t;

  word_t             slots [CAPACITY];
  logic [IDX_W-1:0]  front_slot;
  logic [IDX_W-1:0]  back_slot;
  logic [IDX_W:0]    fill;
  deq_result_t       awaited_results [$];
  int                errors = 0;

  function automatic logic [IDX_W-1:0] slot_inc(logic [IDX_W-1:0] i);
    return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_dec(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
  endfunction

  // applies one request to the shadow deque and returns its response
  function automatic deq_result_t deque_apply(logic [OP_W-1:0] op, word_t value);
    deq_result_t      res;
    logic [IDX_W-1:0] slot;
    res.read_value = '0;
    res.status     = ST_OK;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (fill == (IDX_W + 1)'(CAPACITY)) begin
          res.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          slots[back_slot] = value;
          back_slot = slot_inc(back_slot);
          fill = fill + 1'b1;
        end else begin
          front_slot = slot_dec(front_slot);
          slots[front_slot] = value;
          fill = fill + 1'b1;
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
        if (fill == '0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = (op == OP_POP_BACK || op == OP_PEEK_BACK) ? slot_dec(back_slot) : front_slot;
          res.read_value = slots[slot];
          if (op == OP_POP_BACK) begin
            back_slot = slot;
            fill = fill - 1'b1;
          end else if (op == OP_POP_FRONT) begin
            front_slot = slot_inc(front_slot);
            fill = fill - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    deq_result_t exp_res;
    deq_result_t new_res;
    if (rst) begin
      front_slot = '0;
      back_slot  = '0;
      fill       = '0;
      awaited_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $error("response word with no request waiting: read_value %0d status %0d",
                 rsp.read_value, rsp.status);
          errors++;
        end else begin
          exp_res = awaited_results[0];
          awaited_results.delete(0);
          if (rsp.read_value !== exp_res.read_value) begin
            $error("read_value: expected %0d, actual %0d", exp_res.read_value,
                   rsp.read_value);
            errors++;
          end
          if (rsp.status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, rsp.status);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        new_res = deque_apply(req.op, req.push_value);
        awaited_results.insert(awaited_results.size(), new_res);
      end
    end
    outstanding <= awaited_results.size();
    fail_count  <= errors;
  end

endmodule

/* sim/tb_double_ended_queue.sv */
// testbench top for the double-ended queue: clock, reset, stimulus and verdict
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int RANDOM_WORDS = 1550;
  localparam int IDLE_LIMIT   = 2000;

  // codes with no operation behind them
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} op_mix_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   burst_left;
  int   sent_words;
  int   idle_cycles = 0;
  int   stall_left = 0;
  int   stall_mode = 0;
  logic [7:0] stall_pattern;
  logic [2:0] stall_phase = '0;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  deq_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(op_mix_t mix);
    int r;
    logic front;
    r = $urandom_range(0, 99);
    front = 1'($urandom_range(0, 1));
    if (mix == MIX_NOISE) begin
      return OP_W'($urandom_range(0, 7));
    end
    if ((mix == MIX_FILL && r < 70) || (mix == MIX_DRAIN && r >= 80) ||
        (mix == MIX_BALANCED && r < 40)) begin
      return front ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end
    if ((mix == MIX_FILL && r >= 85) || (mix == MIX_DRAIN && r < 60) ||
        (mix == MIX_BALANCED && r < 75)) begin
      return front ? OP_POP_FRONT : OP_POP_BACK;
    end
    if (mix == MIX_BALANCED && r >= 95) begin
      return front ? OP_SPARE_HI : OP_SPARE_LO;
    end
    return front ? OP_PEEK_FRONT : OP_PEEK_BACK;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input word_t value);
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.push_value <= value;
    do @(posedge clk); while (!req_ch.ready);
    sent_words++;
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic drain_wait();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    op_mix_t mix;
    int      phase_len;
    int      phase_idx;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_PUSH_BACK;
    req_ch.push_value <= '0;
    burst_left = 8;
    sent_words = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty deque, unused codes, extremes at both ends
    send_word(OP_POP_BACK, 32'sh12345678);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_PEEK_BACK, '0);
    send_word(OP_PEEK_FRONT, '1);
    send_word(OP_SPARE_LO, 32'sh7fffffff);
    send_word(OP_SPARE_HI, 32'sh80000000);
    send_word(OP_PUSH_BACK, 32'sh7fffffff);
    send_word(OP_PUSH_FRONT, 32'sh80000000);
    send_word(OP_PEEK_BACK, '0);
    send_word(OP_PEEK_FRONT, '0);
    send_word(OP_PUSH_BACK, '0);
    send_word(OP_PUSH_FRONT, '1);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_PEEK_BACK, '0);

    phase_idx = 0;
    sent_words = 0;
    while (sent_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: mix = MIX_FILL;
        3, 4, 5: mix = MIX_DRAIN;
        6, 7, 8: mix = MIX_BALANCED;
        default: mix = MIX_NOISE;
      endcase
      phase_len = $urandom_range(30, 110);
      repeat (phase_len) send_word(pick_op(mix), pick_word());
      if (phase_idx == 0 || $urandom_range(0, 2) == 0) begin
        req_ch.valid <= 1'b0;
        drain_wait();
      end
      phase_idx++;
    end

    req_ch.valid <= 1'b0;
    drain_wait();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // response side stalls on its own pattern, with stretches of no stall
  always @(posedge clk) begin
    if (stall_left <= 0) begin
      stall_mode    <= $urandom_range(0, 2);
      stall_pattern <= 8'($urandom_range(1, 255));
      stall_left    <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1'b1;
    case (stall_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= stall_pattern[stall_phase];
      default: rsp_ch.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
